>>> sv/scsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scsd_pkg
// Shared types and constants of the serial speed command decoder.
// ----------------------------------------------------------------------------
package scsd_pkg;

    localparam int LINE_CHARS = 32;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 16;
    localparam int DUTY_W  = 8;
    localparam int MAG_W   = 16;
    localparam int ACC_W   = MAG_W + 3;
    localparam int COUNT_W = 8;

    localparam logic [COUNT_W-1:0] LINE_LIMIT       = COUNT_W'(LINE_CHARS - 1);
    localparam logic [BYTE_W-1:0]  END_MARKER_RESET = 8'd10;

    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'd43;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'd57;

    localparam logic [MAG_W-1:0] MAG_CAP  = 16'd32768;
    localparam logic [MAG_W-1:0] POS_MAX  = 16'd32767;
    localparam logic [MAG_W-1:0] DUTY_MAX = 16'd255;

    localparam int TDATA_W = 32;

    typedef struct packed {
        logic                saturated;
        logic [DUTY_W-1:0]   duty;
        logic                reverse;
        logic [VALUE_W-1:0]  command_value;
    } result_t;

    typedef struct packed {
        logic fire_end;
    } parse_status_t;

endpackage
`default_nettype wire

>>> sv/serial_speed_command_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_speed_command_decoder_unit
// Parses lines of ASCII bytes as signed decimal speed commands.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  s_      | in  | one received byte
//  m_      | out | value, direction, duty, clamp flag; one word per line
//  cfg_    | in  | end marker byte
//
//  One byte per cycle unless an end marker waits on the m_ side; each byte is held in the input register.
//  The result appears at the output register in the cycle after its end marker is parsed.
//  Reset clears the parse state, direction forward, end marker 10.
//  A stalled m_ side holds an end marker in the input register and the bytes behind it; other bytes keep flowing.
// ----------------------------------------------------------------------------
module serial_speed_command_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] command_value, [16] reverse,
                                        // [24:17] duty, [25] saturated
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_wdata  // end_marker
);
    import scsd_pkg::*;

    logic [BYTE_W-1:0] end_marker_reg;
    logic              slot_free;
    result_t           result;
    result_t           out_word;
    parse_status_t     status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_marker_reg <= END_MARKER_RESET;
        end else if (cfg_valid) begin
            end_marker_reg <= cfg_wdata;
        end
    end

    scsd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .end_marker (end_marker_reg),
        .slot_free  (slot_free),
        .result     (result),
        .status     (status)
    );

    scsd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .status    (status),
        .result    (result),
        .slot_free (slot_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = {(TDATA_W - $bits(result_t))'(0), out_word};

`ifndef SYNTHESIS
    a_valid_from_end_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> $past(status.fire_end))
        else $error("result word without end marker");

    a_duty_clamp_flagged: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[24:17] == 8'hFF && m_tdata[15:0] != 16'd255
         && m_tdata[15:0] != 16'hFF01) |-> m_tdata[25])
        else $error("duty clamp without saturated flag");

    a_negative_reverse: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[15]) |-> m_tdata[16])
        else $error("negative value without reverse");
`endif

endmodule
`default_nettype wire

>>> sv/scsd_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scsd_parser
// Input byte register and per-line decimal parse state; builds the line result.
// ----------------------------------------------------------------------------
module scsd_parser (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [scsd_pkg::BYTE_W-1:0] in_byte,
    input  wire logic [scsd_pkg::BYTE_W-1:0] end_marker,
    input  wire logic                     slot_free,
    output scsd_pkg::result_t             result,
    output scsd_pkg::parse_status_t       status
);
    import scsd_pkg::*;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    logic               byte_valid_reg;
    logic [BYTE_W-1:0]  byte_reg;
    phase_t             phase_reg, phase_next;
    logic               negative_reg, negative_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               direction_reg, direction_next;
    logic               clamp_reg, clamp_next;

    logic               is_end, fire, is_digit, is_blank, is_sign;
    logic [ACC_W-1:0]   acc;
    logic [MAG_W-1:0]   mag_out;
    logic               sat;

    assign is_end   = (byte_reg == end_marker);
    assign fire     = byte_valid_reg && (!is_end || slot_free);
    assign in_ready = !byte_valid_reg || fire;

    assign is_digit = (byte_reg >= CHAR_ZERO) && (byte_reg <= CHAR_NINE);
    assign is_blank = (byte_reg == CHAR_SPACE) || ((byte_reg >= CHAR_TAB) && (byte_reg <= CHAR_CR));
    assign is_sign  = (byte_reg == CHAR_PLUS) || (byte_reg == CHAR_MINUS);
    assign acc      = ({3'b000, mag_reg} << 3) + ({3'b000, mag_reg} << 1)
                    + ACC_W'(byte_reg - CHAR_ZERO);

    always_comb begin
        mag_out = mag_reg;
        sat     = 1'b0;
        if (negative_reg) begin
            sat = clamp_reg;
        end else if (mag_reg > POS_MAX) begin
            mag_out = POS_MAX;
            sat     = 1'b1;
        end
        result.reverse = (mag_out != '0) ? negative_reg : direction_reg;
        if (mag_out > DUTY_MAX) begin
            result.duty = '1;
            sat         = 1'b1;
        end else begin
            result.duty = mag_out[DUTY_W-1:0];
        end
        result.saturated     = sat;
        result.command_value = negative_reg ? (VALUE_W'(0) - mag_out) : mag_out;
    end

    always_comb begin
        phase_next     = phase_reg;
        negative_next  = negative_reg;
        mag_next       = mag_reg;
        count_next     = count_reg;
        direction_next = direction_reg;
        clamp_next     = clamp_reg;
        if (fire) begin
            if (is_end) begin
                direction_next = result.reverse;
                phase_next     = PH_LEAD;
                negative_next  = 1'b0;
                mag_next       = '0;
                count_next     = '0;
                clamp_next     = 1'b0;
            end else if (count_reg < LINE_LIMIT) begin
                count_next = count_reg + COUNT_W'(1);
                if (phase_reg != PH_DONE) begin
                    if (phase_reg == PH_LEAD && is_blank) begin
                        phase_next = phase_reg;
                    end else if (phase_reg == PH_LEAD && is_sign) begin
                        negative_next = (byte_reg == CHAR_MINUS);
                        phase_next    = PH_SIGN;
                    end else if (!is_digit) begin
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_DIGITS;
                        if (acc > ACC_W'(MAG_CAP)) begin
                            mag_next   = MAG_CAP;
                            clamp_next = 1'b1;
                        end else begin
                            mag_next = acc[MAG_W-1:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg <= 1'b0;
            phase_reg      <= PH_LEAD;
            negative_reg   <= 1'b0;
            mag_reg        <= '0;
            count_reg      <= '0;
            direction_reg  <= 1'b0;
            clamp_reg      <= 1'b0;
        end else begin
            if (in_ready) begin
                byte_valid_reg <= in_valid;
            end
            phase_reg     <= phase_next;
            negative_reg  <= negative_next;
            mag_reg       <= mag_next;
            count_reg     <= count_next;
            direction_reg <= direction_next;
            clamp_reg     <= clamp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            byte_reg <= in_byte;
        end
    end

    assign status.fire_end = fire && is_end;

endmodule
`default_nettype wire

>>> sv/scsd_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scsd_out_reg
// Result word register toward the master side.
// ----------------------------------------------------------------------------
module scsd_out_reg (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire scsd_pkg::parse_status_t status,
    input  wire scsd_pkg::result_t       result,
    output logic                         slot_free,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output scsd_pkg::result_t            out_word
);
    import scsd_pkg::*;

    logic    valid_reg;
    result_t word_reg;

    assign slot_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (status.fire_end) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (status.fire_end) begin
            word_reg <= result;
        end
    end

endmodule
`default_nettype wire
